FILE: rtl/tsem_pkg.sv
package tsem_pkg;

	localparam int COORD_W    = 20;
	localparam int REG_W      = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_METHOD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EDGE   = 2'd3;

	localparam logic [1:0] METH_NEAREST  = 2'd0;
	localparam logic [1:0] METH_BILINEAR = 2'd1;
	localparam logic [1:0] METH_BICUBIC  = 2'd2;

	localparam logic [1:0] EDGE_ZERO   = 2'd0;
	localparam logic [1:0] EDGE_CLAMP  = 2'd1;
	localparam logic [1:0] EDGE_REPEAT = 2'd2;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef struct packed {
		logic                      operation;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic [7:0]                red;
		logic [7:0]                green;
		logic [7:0]                blue;
		logic [7:0]                alpha;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
	} out_item_t;

	typedef struct packed {
		logic       start;
		logic [1:0] method;
	} filt_ctrl_t;

endpackage

FILE: rtl/tsem_pixel_mem.sv
module tsem_pixel_mem #(
	parameter int DEPTH  = 65536,
	parameter int ADDR_W = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ADDR_W-1:0] addr,
	input  logic              we,
	input  logic [31:0]       wdata,
	output logic [31:0]       rdata,
	output logic              clearing
);
	logic [31:0]       mem [DEPTH];
	logic              clr_q;
	logic [ADDR_W-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

	assign clearing = clr_q;

endmodule

FILE: rtl/tsem_wrap.sv
module tsem_wrap #(
	parameter int CRW   = 14,
	parameter int DIM_W = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [CRW-1:0] ax,
	input  logic signed [CRW-1:0] ay,
	input  logic [DIM_W-1:0]      dx,
	input  logic [DIM_W-1:0]      dy,
	output logic                  done,
	output logic [DIM_W-1:0]      rem_x,
	output logic [DIM_W-1:0]      rem_y
);
	import tsem_pkg::*;

	localparam int CNT_W = $clog2(CRW + 1);

	logic             run_q, done_q, negx_q, negy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CRW-1:0]   magx_q, magy_q;
	logic [DIM_W-1:0] rx_q, ry_q;
	logic [DIM_W:0]   tx, ty;

	// restoring remainder, one bit per cycle for both axes
	assign tx = {rx_q, magx_q[CRW-1]};
	assign ty = {ry_q, magy_q[CRW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(CRW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			negx_q <= ax[CRW-1];
			negy_q <= ay[CRW-1];
			magx_q <= ax[CRW-1] ? CRW'(-ax) : CRW'(ax);
			magy_q <= ay[CRW-1] ? CRW'(-ay) : CRW'(ay);
			rx_q   <= '0;
			ry_q   <= '0;
		end else if (run_q) begin
			magx_q <= magx_q << 1;
			magy_q <= magy_q << 1;
			rx_q   <= (tx >= {1'b0, dx}) ? DIM_W'(tx - {1'b0, dx}) : DIM_W'(tx);
			ry_q   <= (ty >= {1'b0, dy}) ? DIM_W'(ty - {1'b0, dy}) : DIM_W'(ty);
		end
	end

	// floor modulo: a negative value with a remainder folds back from the divisor
	assign rem_x = (negx_q && rx_q != '0) ? DIM_W'(dx - rx_q) : rx_q;
	assign rem_y = (negy_q && ry_q != '0) ? DIM_W'(dy - ry_q) : ry_q;
	assign done  = done_q;

endmodule

FILE: rtl/tsem_filter.sv
module tsem_filter #(
	parameter int FRAC_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tsem_pkg::filt_ctrl_t ctrl,
	input  logic                 cap_valid,
	input  logic [31:0]          cap_data,
	input  logic [FRAC_BITS-1:0] fx,
	input  logic [FRAC_BITS-1:0] fy,
	output logic                 done,
	output logic [31:0]          color
);
	import tsem_pkg::*;

	localparam int AW = FRAC_BITS + 16;
	localparam int PW = AW + FRAC_BITS + 1;
	localparam int LW = FRAC_BITS + 10;
	localparam logic [LW-1:0] FONE = LW'(1) << FRAC_BITS;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_ROW  = 2'd1;
	localparam logic [1:0] F_COL  = 2'd2;
	localparam logic [1:0] F_LIN  = 2'd3;

	logic [1:0]           phase_q, step_q, row_q;
	logic                 done_q, row_mode;
	logic [31:0]          px_q [16];
	logic [31:0]          top_q, bot_q, color_q;
	logic [31:0]          lin_a, lin_b, lerp_v, clamp_v;
	logic [FRAC_BITS-1:0] lin_f, tsel;

	assign row_mode = (phase_q == F_ROW);
	assign tsel     = row_mode ? fx : fy;
	assign lin_a    = (step_q == 2'd0) ? px_q[12] : (step_q == 2'd1) ? px_q[14] : top_q;
	assign lin_b    = (step_q == 2'd0) ? px_q[13] : (step_q == 2'd1) ? px_q[15] : bot_q;
	assign lin_f    = (step_q == 2'd2) ? fy : fx;

	for (genvar c = 0; c < 4; c++) begin : g_lane
		logic signed [AW-1:0] p0, p1, p2, p3, ca, cb, cc, cd, csel;
		logic signed [AW-1:0] sa, ssel, prodsh, acc_d, fin;
		logic signed [PW-1:0] prod;
		logic signed [AW-1:0] acc_q;
		logic signed [AW-1:0] rowv_q [4];
		logic [LW-1:0]        lsum;

		assign p0 = row_mode ? signed'(AW'(px_q[0][8*c +: 8])) : rowv_q[0];
		assign p1 = row_mode ? signed'(AW'(px_q[1][8*c +: 8])) : rowv_q[1];
		assign p2 = row_mode ? signed'(AW'(px_q[2][8*c +: 8])) : rowv_q[2];
		assign p3 = row_mode ? signed'(AW'(px_q[3][8*c +: 8])) : rowv_q[3];

		// doubled catmull-rom coefficients
		assign ca = p3 - p0 + ((p1 - p2) <<< 1) + (p1 - p2);
		assign cb = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
		assign cc = p2 - p0;
		assign cd = p1 <<< 1;

		always_comb begin
			case (step_q)
				2'd1:    csel = cb;
				2'd2:    csel = cc;
				default: csel = cd;
			endcase
		end

		assign sa     = row_mode ? (ca <<< FRAC_BITS) : ca;
		assign ssel   = row_mode ? (csel <<< FRAC_BITS) : csel;
		assign prod   = PW'(acc_q) * signed'(PW'({1'b0, tsel}));
		assign prodsh = AW'(prod >>> FRAC_BITS);
		assign acc_d  = (step_q == 2'd0) ? sa : prodsh + ssel;
		assign fin    = acc_d >>> (FRAC_BITS + 2);

		assign clamp_v[8*c +: 8] = fin[AW-1] ? 8'd0 :
			(fin > signed'(AW'(255))) ? 8'd255 : fin[7:0];

		assign lsum = LW'(lin_a[8*c +: 8]) * (FONE - LW'(lin_f))
			+ LW'(lin_b[8*c +: 8]) * LW'(lin_f);
		assign lerp_v[8*c +: 8] = lsum[FRAC_BITS +: 8];

		always_ff @(posedge clk) begin
			if (phase_q == F_ROW || phase_q == F_COL) begin
				acc_q <= acc_d;
			end
			if (row_mode && step_q == 2'd3) begin
				rowv_q[0] <= rowv_q[1];
				rowv_q[1] <= rowv_q[2];
				rowv_q[2] <= rowv_q[3];
				rowv_q[3] <= acc_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= F_IDLE;
			step_q  <= '0;
			row_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				F_IDLE: begin
					step_q <= '0;
					row_q  <= '0;
					if (ctrl.start) begin
						case (ctrl.method)
							METH_NEAREST:  done_q  <= 1'b1;
							METH_BILINEAR: phase_q <= F_LIN;
							default:       phase_q <= F_ROW;
						endcase
					end
				end
				F_ROW: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd3) begin
						row_q <= row_q + 1'b1;
						if (row_q == 2'd3) begin
							phase_q <= F_COL;
						end
					end
				end
				F_COL: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd3) begin
						done_q  <= 1'b1;
						phase_q <= F_IDLE;
					end
				end
				F_LIN: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd2) begin
						done_q  <= 1'b1;
						phase_q <= F_IDLE;
					end
				end
				default: phase_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cap_valid) begin
			for (int i = 0; i < 15; i++) begin
				px_q[i] <= px_q[i+1];
			end
			px_q[15] <= cap_data;
		end else if (row_mode && step_q == 2'd3) begin
			for (int i = 0; i < 12; i++) begin
				px_q[i] <= px_q[i+4];
			end
		end
		if (phase_q == F_IDLE && ctrl.start && ctrl.method == METH_NEAREST) begin
			color_q <= px_q[15];
		end
		if (phase_q == F_COL && step_q == 2'd3) begin
			color_q <= clamp_v;
		end
		if (phase_q == F_LIN) begin
			case (step_q)
				2'd0:    top_q   <= lerp_v;
				2'd1:    bot_q   <= lerp_v;
				default: color_q <= lerp_v;
			endcase
		end
	end

	assign done  = done_q;
	assign color = color_q;

endmodule

FILE: rtl/texture_sampler_with_edge_modes.sv
// RGBA texture sampler. Holds a MAX_DIM x MAX_DIM store of 32-bit pixels in one
// single-port synchronous memory. After reset the store is cleared one word per
// cycle; busy stays high and no start is taken until it is done, while register
// writes work at any time. A start is taken when busy is low; one item is worked
// on at a time. A pixel write gives no result, also when it falls outside the
// image. A sample gives one result on done for one cycle, which the receiver must
// take then. A sample makes one memory read per neighbor (1, 4 or 16 for nearest,
// bilinear and bicubic), then passes the read pipeline and the shared filter
// lanes; in repeat edge mode, nearest and bicubic samples first pass the
// bit-serial remainder unit. Samples that resolve to zero at once skip the reads.
module texture_sampler_with_edge_modes #(
	parameter int MAX_DIM   = 256,
	parameter int FRAC_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  tsem_pkg::in_item_t                item,
	output logic                              done,
	output tsem_pkg::out_item_t               result,
	input  logic                              cfg_we,
	input  logic [tsem_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tsem_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tsem_pkg::*;

	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CRW    = (22 - FRAC_BITS > DIM_W + 2) ? 22 - FRAC_BITS : DIM_W + 2;
	localparam int CMPW   = (DIM_W > REG_W) ? DIM_W : REG_W;
	localparam int MW     = 2 * DIM_W;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_PREP  = 3'd2;
	localparam logic [2:0] S_MOD   = 3'd3;
	localparam logic [2:0] S_FETCH = 3'd4;
	localparam logic [2:0] S_DRAIN = 3'd5;
	localparam logic [2:0] S_FILT  = 3'd6;
	localparam logic [2:0] S_WRITE = 3'd7;

	function automatic logic signed [CRW-1:0] round_coord(input logic signed [COORD_W-1:0] v);
		logic signed [COORD_W:0] ve, mag, rs;
		ve  = (COORD_W + 1)'(v);
		mag = v[COORD_W-1] ? -ve : ve;
		rs  = (mag + ((COORD_W + 1)'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
		return v[COORD_W-1] ? -CRW'(rs) : CRW'(rs);
	endfunction

	function automatic logic [DIM_W-1:0] inc_wrap(input logic [DIM_W-1:0] v,
		input logic step, input logic [DIM_W-1:0] lim);
		logic [DIM_W:0] n;
		n = (DIM_W + 1)'(v) + (DIM_W + 1)'(step);
		return (n == {1'b0, lim}) ? '0 : DIM_W'(n);
	endfunction

	logic [2:0]               state_q;
	logic [REG_W-1:0]         img_w_q, img_h_q;
	logic [1:0]               method_q, edge_q;
	logic                     op_q;
	logic signed [COORD_W-1:0] cx_q, cy_q;
	logic [31:0]              col_q, res_q;
	logic                     done_q;

	logic [DIM_W-1:0]         w_eff, h_eff;
	logic signed [CRW-1:0]    ws, hs, ix, iy, ix2, iy2, rnx, rny, st_x, st_y;
	logic [FRAC_BITS-1:0]     fxv, fyv;
	logic                     in_img, bil_ok, no_img, use_mod;

	logic signed [CRW-1:0]    rx_q, ry_q, sx_q;
	logic [DIM_W-1:0]         wx_q, wy_q, bx_q;
	logic [1:0]               ncm_q, nrm_q, cc_q, rc_q;
	logic                     dxs_q, dys_q;

	logic [DIM_W-1:0]         x_r, y_r, x_s1, y_s1;
	logic                     z_r, z_s1, z_s2, vld_s1, vld_s2;

	logic [DIM_W-1:0]         ax_m, ay_m, rem_x, rem_y;
	logic [MW-1:0]            lin_addr;
	logic [31:0]              rdata;
	logic                     clearing, mod_start, mod_done, filt_done;
	logic [31:0]              filt_color;
	filt_ctrl_t               fctl;

	assign w_eff = (CMPW'(img_w_q) > CMPW'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(img_w_q);
	assign h_eff = (CMPW'(img_h_q) > CMPW'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(img_h_q);
	assign ws    = signed'(CRW'(w_eff));
	assign hs    = signed'(CRW'(h_eff));

	assign ix   = CRW'(cx_q >>> FRAC_BITS);
	assign iy   = CRW'(cy_q >>> FRAC_BITS);
	assign fxv  = cx_q[FRAC_BITS-1:0];
	assign fyv  = cy_q[FRAC_BITS-1:0];
	assign ix2  = ix + CRW'(fxv != '0);
	assign iy2  = iy + CRW'(fyv != '0);
	assign rnx  = round_coord(cx_q);
	assign rny  = round_coord(cy_q);

	assign in_img  = !ix[CRW-1] && ix < ws && !iy[CRW-1] && iy < hs;
	assign bil_ok  = !ix[CRW-1] && ix2 < ws && !iy[CRW-1] && iy2 < hs;
	assign no_img  = (w_eff == '0) || (h_eff == '0) || (method_q > METH_BICUBIC)
		|| (method_q == METH_BILINEAR && !bil_ok);
	assign use_mod = (edge_q == EDGE_REPEAT) && (method_q != METH_BILINEAR);

	always_comb begin
		case (method_q)
			METH_NEAREST: begin
				st_x = rnx;
				st_y = rny;
			end
			METH_BILINEAR: begin
				st_x = ix;
				st_y = iy;
			end
			default: begin
				st_x = ix - CRW'(1);
				st_y = iy - CRW'(1);
			end
		endcase
	end

	assign mod_start = (state_q == S_PREP) && (op_q == OP_SAMPLE) && !no_img && use_mod;

	// neighbour address resolution by edge mode
	always_comb begin
		x_r = DIM_W'(rx_q);
		y_r = DIM_W'(ry_q);
		z_r = 1'b0;
		case (edge_q)
			EDGE_ZERO: begin
				z_r = rx_q[CRW-1] || rx_q >= ws || ry_q[CRW-1] || ry_q >= hs;
			end
			EDGE_CLAMP: begin
				if (rx_q[CRW-1]) begin
					x_r = '0;
				end else if (rx_q >= ws) begin
					x_r = w_eff - 1'b1;
				end
				if (ry_q[CRW-1]) begin
					y_r = '0;
				end else if (ry_q >= hs) begin
					y_r = h_eff - 1'b1;
				end
			end
			EDGE_REPEAT: begin
				x_r = wx_q;
				y_r = wy_q;
			end
			default: z_r = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q  <= '0;
			img_h_q  <= '0;
			method_q <= '0;
			edge_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIDTH:  img_w_q  <= cfg_data;
				CFG_HEIGHT: img_h_q  <= cfg_data;
				CFG_METHOD: method_q <= cfg_data[1:0];
				CFG_EDGE:   edge_q   <= cfg_data[1:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= (state_q == S_FETCH);
			vld_s2 <= vld_s1;
			case (state_q)
				S_CLEAR: begin
					if (!clearing) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (op_q == OP_WRITE) begin
						state_q <= in_img ? S_WRITE : S_IDLE;
					end else if (no_img) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= use_mod ? S_MOD : S_FETCH;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					if (cc_q == ncm_q && rc_q == nrm_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!vld_s1 && !vld_s2) begin
						state_q <= S_FILT;
					end
				end
				S_FILT: begin
					if (filt_done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_WRITE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q  <= item.operation;
			cx_q  <= item.coord_x;
			cy_q  <= item.coord_y;
			col_q <= {item.alpha, item.blue, item.green, item.red};
		end
		if (state_q == S_PREP) begin
			if (op_q == OP_WRITE) begin
				wx_q <= DIM_W'(ix);
				wy_q <= DIM_W'(iy);
			end else begin
				rx_q  <= st_x;
				ry_q  <= st_y;
				sx_q  <= st_x;
				wx_q  <= DIM_W'(st_x);
				bx_q  <= DIM_W'(st_x);
				wy_q  <= DIM_W'(st_y);
				cc_q  <= '0;
				rc_q  <= '0;
				case (method_q)
					METH_NEAREST: begin
						ncm_q <= 2'd0;
						nrm_q <= 2'd0;
						dxs_q <= 1'b1;
						dys_q <= 1'b1;
					end
					METH_BILINEAR: begin
						ncm_q <= 2'd1;
						nrm_q <= 2'd1;
						dxs_q <= (fxv != '0);
						dys_q <= (fyv != '0);
					end
					default: begin
						ncm_q <= 2'd3;
						nrm_q <= 2'd3;
						dxs_q <= 1'b1;
						dys_q <= 1'b1;
					end
				endcase
			end
			if (no_img) begin
				res_q <= '0;
			end
		end
		if (state_q == S_MOD && mod_done) begin
			wx_q <= rem_x;
			bx_q <= rem_x;
			wy_q <= rem_y;
		end
		if (state_q == S_FETCH) begin
			if (cc_q == ncm_q) begin
				cc_q <= '0;
				rc_q <= rc_q + 1'b1;
				rx_q <= sx_q;
				wx_q <= bx_q;
				ry_q <= ry_q + CRW'(dys_q);
				wy_q <= inc_wrap(wy_q, dys_q, h_eff);
			end else begin
				cc_q <= cc_q + 1'b1;
				rx_q <= rx_q + CRW'(dxs_q);
				wx_q <= inc_wrap(wx_q, dxs_q, w_eff);
			end
		end
		if (state_q == S_FILT && filt_done) begin
			res_q <= filt_color;
		end
		x_s1 <= x_r;
		y_s1 <= y_r;
		z_s1 <= z_r;
		z_s2 <= z_s1;
	end

	assign ax_m     = (state_q == S_WRITE) ? wx_q : x_s1;
	assign ay_m     = (state_q == S_WRITE) ? wy_q : y_s1;
	assign lin_addr = MW'(ay_m) * MW'(w_eff) + MW'(ax_m);

	tsem_pixel_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.addr     (ADDR_W'(lin_addr)),
		.we       (state_q == S_WRITE),
		.wdata    (col_q),
		.rdata    (rdata),
		.clearing (clearing)
	);

	tsem_wrap #(
		.CRW   (CRW),
		.DIM_W (DIM_W)
	) u_wrap (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.ax     (st_x),
		.ay     (st_y),
		.dx     (w_eff),
		.dy     (h_eff),
		.done   (mod_done),
		.rem_x  (rem_x),
		.rem_y  (rem_y)
	);

	assign fctl.start  = (state_q == S_DRAIN) && !vld_s1 && !vld_s2;
	assign fctl.method = method_q;

	tsem_filter #(
		.FRAC_BITS (FRAC_BITS)
	) u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (fctl),
		.cap_valid (vld_s2),
		.cap_data  (z_s2 ? 32'd0 : rdata),
		.fx        (fxv),
		.fy        (fyv),
		.done      (filt_done),
		.color     (filt_color)
	);

	assign busy             = (state_q != S_IDLE);
	assign done             = done_q;
	assign result.out_red   = res_q[7:0];
	assign result.out_green = res_q[15:8];
	assign result.out_blue  = res_q[23:16];
	assign result.out_alpha = res_q[31:24];

	// one result per transaction, never on back-to-back cycles
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == S_PREP || $past(state_q) == S_FILT))
		else $error("result without sample");

	a_fetch_src: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(state_q) == S_FETCH)
		else $error("stray neighbour read");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> busy)
		else $error("start open during clear");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import tsem_pkg::*;

	localparam int DIM      = 256;
	localparam int PAUSE    = 100;
	localparam int LIMIT    = 3000000;

	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		in_item_t              it;
		bit                    typed;
		out_item_t             exp;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t item;
	logic done;
	out_item_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bit [31:0] pixel_model [DIM*DIM];
	logic [8:0] img_w, img_h;
	logic [1:0] samp_method, edge_sel;

	out_item_t expected_colors[$];
	stim_row_t directed[$];
	int n_fail, n_samples, n_writes, n_checked, n_phases;
	int cycles;

	texture_sampler_with_edge_modes i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic longint eff_dim(logic [8:0] v);
		return (v > DIM) ? DIM : longint'(v);
	endfunction

	function automatic logic [31:0] fetch_px(longint x, longint y);
		longint w, h;
		w = eff_dim(img_w);
		h = eff_dim(img_h);
		case (edge_sel)
			EDGE_ZERO: begin
				if (x < 0 || x >= w || y < 0 || y >= h) return 0;
			end
			EDGE_CLAMP: begin
				if (x < 0) x = 0;
				if (x > w - 1) x = w - 1;
				if (y < 0) y = 0;
				if (y > h - 1) y = h - 1;
			end
			EDGE_REPEAT: begin
				x = x % w;
				if (x < 0) x += w;
				y = y % h;
				if (y < 0) y += h;
			end
			default: return 0;
		endcase
		return pixel_model[y*w + x];
	endfunction

	function automatic logic [31:0] lerp_px(logic [31:0] a, logic [31:0] b, longint f);
		logic [31:0] r;
		longint v;
		r = 0;
		for (int c = 0; c < 4; c++) begin
			v = (longint'(a[c*8 +: 8]) * (256 - f) + longint'(b[c*8 +: 8]) * f) >>> 8;
			r[c*8 +: 8] = v[7:0];
		end
		return r;
	endfunction

	function automatic longint catmull_rom(longint p0, longint p1, longint p2, longint p3,
			longint t, longint mul);
		longint a, b, c, d, acc;
		a = (-p0 + 3*p1 - 3*p2 + p3) * mul;
		b = (2*p0 - 5*p1 + 4*p2 - p3) * mul;
		c = (p2 - p0) * mul;
		d = (2*p1) * mul;
		acc = a;
		acc = ((acc * t) >>> 8) + b;
		acc = ((acc * t) >>> 8) + c;
		acc = ((acc * t) >>> 8) + d;
		return acc;
	endfunction

	function automatic longint round_coord(longint v);
		if (v >= 0) return (v + 128) >>> 8;
		return -((-v + 128) >>> 8);
	endfunction

	function automatic out_item_t sample_color(longint vx, longint vy);
		longint w, h, fx, fy, ix, iy, ix2, iy2, acc;
		longint row[4];
		logic [31:0] res, top, bot;
		logic [31:0] px[16];
		w = eff_dim(img_w);
		h = eff_dim(img_h);
		fx = vx & 255;
		fy = vy & 255;
		ix = vx >>> 8;
		iy = vy >>> 8;
		res = 0;
		if (w > 0 && h > 0) begin
			case (samp_method)
				METH_NEAREST: res = fetch_px(round_coord(vx), round_coord(vy));
				METH_BILINEAR: begin
					ix2 = ix + (fx != 0);
					iy2 = iy + (fy != 0);
					if (ix >= 0 && ix2 < w && iy >= 0 && iy2 < h) begin
						top = lerp_px(fetch_px(ix, iy), fetch_px(ix2, iy), fx);
						bot = lerp_px(fetch_px(ix, iy2), fetch_px(ix2, iy2), fx);
						res = lerp_px(top, bot, fy);
					end
				end
				METH_BICUBIC: begin
					for (int k = 0; k < 16; k++)
						px[k] = fetch_px(ix - 1 + (k & 3), iy - 1 + (k >> 2));
					for (int c = 0; c < 4; c++) begin
						for (int j = 0; j < 4; j++)
							row[j] = catmull_rom(px[j*4][c*8 +: 8], px[j*4+1][c*8 +: 8],
								px[j*4+2][c*8 +: 8], px[j*4+3][c*8 +: 8], fx, 256);
						acc = catmull_rom(row[0], row[1], row[2], row[3], fy, 1) >>> 10;
						if (acc < 0) acc = 0;
						if (acc > 255) acc = 255;
						res[c*8 +: 8] = acc[7:0];
					end
				end
				default: res = 0;
			endcase
		end
		return '{res[7:0], res[15:8], res[23:16], res[31:24]};
	endfunction

	// update the image copy, or queue the color that a sample returns
	function automatic void account_item(in_item_t it);
		longint ix, iy, w, h;
		w = eff_dim(img_w);
		h = eff_dim(img_h);
		ix = longint'(it.coord_x) >>> 8;
		iy = longint'(it.coord_y) >>> 8;
		if (it.operation == OP_WRITE) begin
			n_writes++;
			if (ix >= 0 && ix < w && iy >= 0 && iy < h)
				pixel_model[iy*w + ix] = {it.alpha, it.blue, it.green, it.red};
		end else begin
			n_samples++;
			expected_colors.push_back(sample_color(it.coord_x, it.coord_y));
		end
	endfunction

	task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
		n_fail++;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_colors.size() == 0) begin
				$display("unexpected transaction at %0t", $realtime);
				n_fail++;
			end else begin
				out_item_t want;
				want = expected_colors.pop_front();
				n_checked++;
				if (result.out_red !== want.out_red)
					report_mismatch("red", result.out_red, want.out_red);
				if (result.out_green !== want.out_green)
					report_mismatch("green", result.out_green, want.out_green);
				if (result.out_blue !== want.out_blue)
					report_mismatch("blue", result.out_blue, want.out_blue);
				if (result.out_alpha !== want.out_alpha)
					report_mismatch("alpha", result.out_alpha, want.out_alpha);
			end
		end
	end

	task automatic send_item(in_item_t it, bit typed = 0, out_item_t typed_exp = '0);
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		account_item(it);
		if (typed && it.operation == OP_SAMPLE) begin
			void'(expected_colors.pop_back());
			expected_colors.push_back(typed_exp);
		end
	endtask

	task automatic drain;
		start <= 1'b0;
		do @(posedge clk); while (expected_colors.size() != 0 || busy);
		repeat (PAUSE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_WIDTH:  img_w = data;
			CFG_HEIGHT: img_h = data;
			CFG_METHOD: samp_method = data[1:0];
			default:    edge_sel = data[1:0];
		endcase
	endtask

	function automatic in_item_t make_item(logic op, int x, int y, logic [31:0] px);
		in_item_t it;
		it.operation = op;
		it.coord_x = COORD_W'(x);
		it.coord_y = COORD_W'(y);
		{it.alpha, it.blue, it.green, it.red} = px;
		return it;
	endfunction

	function automatic void cfg_row(logic [CFG_IDX_W-1:0] idx, int data);
		stim_row_t r;
		r = '{default: '0};
		r.is_cfg = 1;
		r.idx = idx;
		r.data = CFG_DATA_W'(data);
		directed.push_back(r);
	endfunction

	function automatic void item_row(logic op, int x, int y, logic [31:0] px,
			bit typed = 0, logic [31:0] want = 0);
		stim_row_t r;
		r = '{default: '0};
		r.it = make_item(op, x, y, px);
		r.typed = typed;
		r.exp = '{want[7:0], want[15:8], want[23:16], want[31:24]};
		directed.push_back(r);
	endfunction

	function automatic int rand_coord(longint dim, bit for_write);
		if ($urandom_range(0, 9) == 0 || dim == 0)
			return int'($urandom);
		if (for_write)
			return $urandom_range(0, int'(dim*256 - 1));
		return int'(-768 + longint'($urandom_range(0, int'((dim + 6) * 256))));
	endfunction

	task automatic run_phase(int pw, int ph, int pm, int pe, int count);
		longint w, h;
		int sent, burst;
		in_item_t it;
		write_reg(CFG_WIDTH, CFG_DATA_W'(pw));
		write_reg(CFG_HEIGHT, CFG_DATA_W'(ph));
		write_reg(CFG_METHOD, CFG_DATA_W'(pm));
		write_reg(CFG_EDGE, CFG_DATA_W'(pe));
		n_phases++;
		w = eff_dim(img_w);
		h = eff_dim(img_h);
		sent = 0;
		if (w * h <= 64) begin
			for (int y = 0; y < h; y++)
				for (int x = 0; x < w; x++) begin
					send_item(make_item(OP_WRITE, x*256 + $urandom_range(0, 255),
						y*256 + $urandom_range(0, 255), $urandom));
					sent++;
				end
		end
		while (sent < count) begin
			burst = $urandom_range(1, 10);
			for (int b = 0; b < burst; b++) begin
				if ($urandom_range(0, 9) < 3)
					it = make_item(OP_WRITE, rand_coord(w, 1), rand_coord(h, 1), $urandom);
				else
					it = make_item(OP_SAMPLE, rand_coord(w, 0), rand_coord(h, 0), $urandom);
				send_item(it);
				sent++;
			end
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		item = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		img_w = 0;
		img_h = 0;
		samp_method = METH_NEAREST;
		edge_sel = EDGE_ZERO;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		item_row(OP_SAMPLE, 0, 0, 0, 1, 32'h0);
		item_row(OP_WRITE, 0, 0, 32'hffffffff);
		item_row(OP_SAMPLE, 0, 0, 0, 1, 32'h0);
		cfg_row(CFG_WIDTH, 4);
		cfg_row(CFG_HEIGHT, 4);
		item_row(OP_WRITE, 0, 0, 32'hffffffff);
		item_row(OP_WRITE, 3*256 + 255, 3*256 + 255, 32'h12345678);
		item_row(OP_WRITE, 1*256, 2*256, 32'h00ff00ff);
		item_row(OP_WRITE, -1, 0, 32'haaaaaaaa);
		item_row(OP_WRITE, 4*256, 0, 32'haaaaaaaa);
		item_row(OP_WRITE, 20'h7ffff, 20'h80000, 32'h55555555);
		item_row(OP_SAMPLE, 0, 0, 0, 1, 32'hffffffff);
		item_row(OP_SAMPLE, 127, 0, 0, 1, 32'hffffffff);
		item_row(OP_SAMPLE, -128, 0, 0, 1, 32'h0);
		item_row(OP_SAMPLE, 20'h7ffff, 20'h80000, 0, 1, 32'h0);
		cfg_row(CFG_EDGE, EDGE_CLAMP);
		item_row(OP_SAMPLE, -2560, -2560, 0, 1, 32'hffffffff);
		item_row(OP_SAMPLE, 20'h7ffff, 20'h7ffff, 0, 1, 32'h12345678);
		cfg_row(CFG_EDGE, EDGE_REPEAT);
		item_row(OP_SAMPLE, -256, -256, 0, 1, 32'h12345678);
		item_row(OP_SAMPLE, 20'h80000, 20'h80000, 0);
		cfg_row(CFG_EDGE, 3);
		item_row(OP_SAMPLE, 0, 0, 0, 1, 32'h0);
		cfg_row(CFG_EDGE, EDGE_ZERO);
		cfg_row(CFG_METHOD, METH_BILINEAR);
		item_row(OP_SAMPLE, 128, 128, 0);
		item_row(OP_SAMPLE, 3*256 + 1, 0, 0, 1, 32'h0);
		item_row(OP_SAMPLE, 2*256 + 77, 2*256 + 200, 0);
		cfg_row(CFG_METHOD, METH_BICUBIC);
		item_row(OP_SAMPLE, 128, 128, 0);
		item_row(OP_SAMPLE, 0, 0, 0);
		item_row(OP_SAMPLE, 3*256 + 255, 511, 0);
		cfg_row(CFG_METHOD, 3);
		item_row(OP_SAMPLE, 256, 256, 0, 1, 32'h0);

		foreach (directed[i]) begin
			if (directed[i].is_cfg)
				write_reg(directed[i].idx, directed[i].data);
			else
				send_item(directed[i].it, directed[i].typed, directed[i].exp);
		end

		run_phase(256, 256, METH_BICUBIC, EDGE_REPEAT, 80);
		run_phase(511, 3, METH_BILINEAR, EDGE_CLAMP, 80);
		run_phase(0, 5, METH_NEAREST, EDGE_ZERO, 40);
		run_phase(6, 300, 3, 3, 40);
		run_phase(1, 1, METH_BICUBIC, EDGE_CLAMP, 60);
		run_phase(2, 7, METH_BICUBIC, EDGE_REPEAT, 80);
		run_phase(8, 8, METH_BILINEAR, EDGE_ZERO, 90);
		for (int p = 0; p < 9; p++)
			run_phase($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(0, 2),
				$urandom_range(0, 3), 90);

		drain();
		$display("covered %0d phases: %0d pixel writes, %0d samples, %0d colors checked",
			n_phases, n_writes, n_samples, n_checked);
		$display("sizes 0..511, all methods and edge modes including unused codes");
		if (n_fail == 0 && expected_colors.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/tsem_pkg.sv
rtl/tsem_pixel_mem.sv
rtl/tsem_wrap.sv
rtl/tsem_filter.sv
rtl/texture_sampler_with_edge_modes.sv
tb/sv/tb.sv
